@@ rtl/ssdp_pkg.sv @@
// Shared constants for the sequence similarity core.
// No dependencies; imported by sequence_similarity_dp_core.
package ssdp_pkg;
    localparam int unsigned QBITS = 30;
    localparam logic [29:0] LIMIT_Q = 30'd655360000;
    localparam logic [31:0] HUNDRED_Q = 32'd6553600;
    localparam logic [22:0] COST_SCALE = 23'd6553600;
    localparam logic [1:0] REQ_FIRST = 2'd0;
    localparam logic [1:0] REQ_SECOND = 2'd1;
    localparam logic [1:0] REQ_RUN = 2'd2;
    typedef logic [29:0] score_t;
endpackage

@@ rtl/sequence_similarity_dp_core.sv @@
// Sequence similarity core: two sequence stores, one row store, one shared
// restoring divider under a cell sequencer. Depends on ssdp_pkg.
//
// channel   dir  handshake         fields
// s_        in   s_valid/s_ready   req_type, elem_value
// m_        out  m_valid/m_ready   final_score, similarity_pct, run_status
//
// A run walks first_len*second_len cells; each cell passes through a read,
// a read-latency step, a divider pass when a cost is needed and a write, and the
// final similarity is a further divider pass (one quotient bit a cycle).
// aresetn is synchronous, active low, and clears lengths and control state.
// s_ready is low during a run and while a result beat waits on m_ready.
module sequence_similarity_dp_core #(
    parameter int MAX_LEN = 1024,
    parameter int ELEM_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_elem_value,
    output logic        m_valid,
    input  logic        m_ready,
    output ssdp_pkg::score_t m_final_score,
    output logic signed [30:0] m_similarity_pct,
    output logic        m_run_status
);
    import ssdp_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = (ELEM_BITS + 1 > LW) ? ELEM_BITS + 1 : LW;
    localparam int NW = (ELEM_BITS + 23 > LW + 30) ? ELEM_BITS + 23 : LW + 30;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_LAT  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;

    logic [ELEM_BITS-1:0] first_mem [MAX_LEN];
    logic [ELEM_BITS-1:0] second_mem [MAX_LEN];
    score_t row_mem [MAX_LEN];

    logic [2:0] state_reg, state_next;
    logic [LW-1:0] first_len_reg, second_len_reg;
    logic [AW-1:0] i_reg, j_reg;
    logic [ELEM_BITS-1:0] x_rd_reg, y_rd_reg;
    score_t row_rd_reg, diag_base_reg, prevj_reg, left_reg, c00_reg, cost_reg;
    logic zd_reg, sim_mode_reg;
    logic [NW-1:0] rem_reg, dsh_reg;
    logic [QBITS-1:0] q_reg;
    logic [4:0] cnt_reg;
    logic m_valid_reg, status_reg;
    score_t score_reg;
    logic [30:0] sim_reg;

    logic [31:0] elem_ext;
    logic accept;
    logic [ELEM_BITS-1:0] diff;
    logic [DW-1:0] den;
    logic need_cost;
    score_t diag_val, left_val, cell_val, diag_sum;
    logic last_i, last_j;

    assign elem_ext = {16'b0, s_elem_value};
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_final_score = score_reg;
    assign m_similarity_pct = sim_reg;
    assign m_run_status = status_reg;

    // Cost operands from the registered element reads
    always_comb begin
        diff = (x_rd_reg > y_rd_reg) ? x_rd_reg - y_rd_reg : y_rd_reg - x_rd_reg;
        den = DW'(x_rd_reg) + DW'(y_rd_reg);
        if (i_reg == '0) begin
            need_cost = (j_reg <= AW'(1));
        end else begin
            need_cost = (j_reg != '0) && (diag_base_reg < LIMIT_Q);
        end
    end

    // Cell value from diagonal and left candidates
    always_comb begin
        diag_sum = diag_base_reg + cost_reg;
        diag_val = LIMIT_Q;
        if (diag_base_reg < LIMIT_Q) begin
            diag_val = zd_reg ? '0 : diag_sum;
        end
        left_val = (i_reg < j_reg) ? left_reg : LIMIT_Q;
        if (i_reg == '0) begin
            if (j_reg == '0) begin
                cell_val = cost_reg;
            end else if (j_reg == AW'(1)) begin
                cell_val = (c00_reg < cost_reg) ? c00_reg : cost_reg;
            end else begin
                cell_val = LIMIT_Q;
            end
        end else if (j_reg == '0) begin
            cell_val = LIMIT_Q;
        end else begin
            cell_val = (left_val < diag_val) ? left_val : diag_val;
        end
        last_i = (LW'(i_reg) + LW'(1)) == first_len_reg;
        last_j = (LW'(j_reg) + LW'(1)) == second_len_reg;
    end

    // Sequence and row stores with registered reads
    always_ff @(posedge aclk) begin
        if (accept && s_req_type == REQ_FIRST && first_len_reg < LW'(MAX_LEN)) begin
            first_mem[first_len_reg[AW-1:0]] <= elem_ext[ELEM_BITS-1:0];
        end
        if (accept && s_req_type == REQ_SECOND && second_len_reg < LW'(MAX_LEN)) begin
            second_mem[second_len_reg[AW-1:0]] <= elem_ext[ELEM_BITS-1:0];
        end
        if (state_reg == ST_WR) begin
            row_mem[j_reg] <= cell_val;
        end
        x_rd_reg <= first_mem[i_reg];
        y_rd_reg <= second_mem[j_reg];
        row_rd_reg <= row_mem[j_reg];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && s_req_type == REQ_RUN &&
                         first_len_reg != '0 && second_len_reg != '0) begin
                state_next = ST_RD;
            end
            ST_RD: state_next = ST_LAT;
            ST_LAT: state_next = (need_cost && den != '0) ? ST_DIV : ST_WR;
            ST_DIV: if (cnt_reg == 5'd1) begin
                state_next = sim_mode_reg ? ST_IDLE : ST_WR;
            end
            ST_WR: state_next = (last_i && last_j) ? ST_DIV : ST_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer, divider and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_len_reg <= '0;
            second_len_reg <= '0;
            m_valid_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            sim_mode_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (accept) begin
                    priority if (s_req_type == REQ_FIRST) begin
                        if (first_len_reg < LW'(MAX_LEN)) first_len_reg <= first_len_reg + 1'b1;
                    end else if (s_req_type == REQ_SECOND) begin
                        if (second_len_reg < LW'(MAX_LEN)) second_len_reg <= second_len_reg + 1'b1;
                    end else if (s_req_type == REQ_RUN) begin
                        i_reg <= '0;
                        j_reg <= '0;
                        sim_mode_reg <= 1'b0;
                        if (first_len_reg == '0 || second_len_reg == '0) begin
                            m_valid_reg <= 1'b1;
                            status_reg <= 1'b1;
                            score_reg <= '0;
                            sim_reg <= '0;
                        end
                    end else begin
                        // drop the unused request code
                    end
                end
                ST_RD: begin
                end
                ST_LAT: begin
                    prevj_reg <= row_rd_reg;
                    zd_reg <= (den == '0);
                    cost_reg <= '0;
                    rem_reg <= NW'(diff * COST_SCALE);
                    dsh_reg <= NW'(den) << 22;
                    q_reg <= '0;
                    cnt_reg <= 5'd23;
                end
                ST_DIV: begin
                    // one quotient bit per beat of the shared divider
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg <= {q_reg[QBITS-2:0], 1'b1};
                    end else begin
                        q_reg <= {q_reg[QBITS-2:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 5'd1) begin
                        if (sim_mode_reg) begin
                            m_valid_reg <= 1'b1;
                            status_reg <= 1'b0;
                            sim_reg <= 31'(32'(HUNDRED_Q - {2'b0, q_reg[QBITS-2:0],
                                (rem_reg >= dsh_reg)}));
                        end else begin
                            cost_reg <= {q_reg[QBITS-2:0], (rem_reg >= dsh_reg)};
                        end
                    end
                end
                ST_WR: begin
                    left_reg <= cell_val;
                    diag_base_reg <= prevj_reg;
                    if (i_reg == '0 && j_reg == '0) c00_reg <= cost_reg;
                    if (last_i && last_j) begin
                        score_reg <= cell_val;
                        sim_mode_reg <= 1'b1;
                        rem_reg <= NW'(cell_val);
                        dsh_reg <= NW'(first_len_reg) << 29;
                        q_reg <= '0;
                        cnt_reg <= 5'd30;
                    end else if (last_j) begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg != ST_IDLE) |-> !s_ready;
    endproperty
    assert property (p_no_accept_busy) else $error("input taken during a run");

    property p_empty_zero;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_run_status) |-> (m_final_score == '0 && m_similarity_pct == '0);
    endproperty
    assert property (p_empty_zero) else $error("empty run with nonzero fields");

    property p_score_bound;
        @(posedge aclk) disable iff (!aresetn)
            m_valid |-> (m_final_score <= 30'd661913600);
    endproperty
    assert property (p_score_bound) else $error("score out of range");

    property p_result_idle;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> (state_reg == ST_IDLE);
    endproperty
    assert property (p_result_idle) else $error("result shown mid run");
endmodule
